### hw/rtl/trcm_pkg.sv
// ----------------------------------------------------------------------------
// trcm_pkg: shared constants for the RSA character modular exponentiator
// Widths, register indexes and reset values used by the top level and the
// bit-serial modular multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trcm_pkg;

  // Width of the value, modulus and exponent words.
  localparam int VALUE_W   = 16;
  localparam int OUT_W     = VALUE_W + 1;
  // Counter over the bits of one word.
  localparam int CNT_W     = $clog2(VALUE_W);
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd2;

  // Offset between character codes and plaintext residues.
  localparam logic [VALUE_W-1:0] CHAR_OFFSET  = VALUE_W'(96);

  localparam logic [VALUE_W-1:0] MODULUS_RST  = VALUE_W'(2);
  localparam logic [VALUE_W-1:0] EXPONENT_RST = VALUE_W'(1);

  localparam logic [CNT_W-1:0]   CNT_LAST     = CNT_W'(VALUE_W - 1);

endpackage

### hw/rtl/trcm_modmul.sv
// ----------------------------------------------------------------------------
// trcm_modmul: bit-serial modular multiplier
// Computes a * b mod n, one bit of a per cycle, MSB first (interleaved
// double-and-add with a conditional subtract after each half step).
// Requires b < n and n >= 2; a may take any value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trcm_modmul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [trcm_pkg::VALUE_W-1:0] op_a,
  input  logic [trcm_pkg::VALUE_W-1:0] op_b,
  input  logic [trcm_pkg::VALUE_W-1:0] modulus,
  output logic                        done,
  output logic [trcm_pkg::VALUE_W-1:0] result
);
  import trcm_pkg::*;

  logic               busy_r,  busy_nxt;
  logic               done_r,  done_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic [VALUE_W-1:0] a_r,     a_nxt;
  logic [VALUE_W-1:0] b_r,     b_nxt;
  logic [VALUE_W-1:0] acc_r,   acc_nxt;

  logic [VALUE_W:0]   dbl;
  logic [VALUE_W:0]   dbl_red;
  logic [VALUE_W:0]   sum;
  logic [VALUE_W:0]   sum_red;

  // One step: acc = 2*acc mod n, then acc = acc + a_bit*b mod n.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    sum     = dbl_red + (a_r[VALUE_W-1] ? {1'b0, b_r} : '0);
    sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = sum_red[VALUE_W-1:0];
      a_nxt   = {a_r[VALUE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

### hw/rtl/textbook_rsa_char_modexp_top.sv
// ----------------------------------------------------------------------------
// textbook_rsa_char_modexp_top: textbook RSA modular exponentiation
// Per word computes base^exponent mod modulus by square-and-multiply. Encrypt
// takes a character code, subtracts 96 and reduces to a non-negative residue;
// decrypt reduces a ciphertext residue and adds 96 to the power.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-------------------------
//   in_      | input     | in_valid / in_stall  | in_value   (16 bit)
//   out_     | output    | out_valid / out_stall| out_value  (17 bit)
//   cfg_     | input     | cfg_we               | cfg_index, cfg_data
//
// One word at a time. Every modular product runs on the shared bit-serial
// multiplier: one base reduction, one squaring per exponent bit and one
// multiply per set bit; a modulus below two skips the multiplier.
// Synchronous active-low reset restores mode 0, modulus 2 and exponent 1.
// A finished word holds in the output register under out_stall while the
// next input word is taken and computed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module textbook_rsa_char_modexp_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [trcm_pkg::VALUE_W-1:0]     in_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [trcm_pkg::OUT_W-1:0]       out_value,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [trcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trcm_pkg::VALUE_W-1:0]     cfg_data
);
  import trcm_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an input word
  localparam logic [2:0] ST_RED  = 3'd1;  // reducing the base mod n
  localparam logic [2:0] ST_STEP = 3'd2;  // pick multiply or square
  localparam logic [2:0] ST_MACC = 3'd3;  // acc * sq in flight
  localparam logic [2:0] ST_SQS  = 3'd4;  // launch squaring
  localparam logic [2:0] ST_MSQ  = 3'd5;  // sq * sq in flight
  localparam logic [2:0] ST_FIN  = 3'd6;  // hand result to output register

  // Configuration registers.
  logic               mode_r;
  logic [VALUE_W-1:0] modulus_r;
  logic [VALUE_W-1:0] exponent_r;

  // Datapath and control.
  logic [2:0]         state_r,     state_nxt;
  logic               neg_r,       neg_nxt;
  logic [VALUE_W-1:0] acc_r,       acc_nxt;
  logic [VALUE_W-1:0] sq_r,        sq_nxt;
  logic [VALUE_W-1:0] exp_sh_r,    exp_sh_nxt;
  logic [CNT_W-1:0]   bit_cnt_r,   bit_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_value_r, out_value_nxt;

  logic               in_accept;
  logic               out_free;
  logic               mod_small;
  logic               in_below;
  logic [VALUE_W-1:0] in_diff;
  logic               mul_start;
  logic [VALUE_W-1:0] mul_a;
  logic [VALUE_W-1:0] mul_b;
  logic               mul_done;
  logic [VALUE_W-1:0] mul_res;
  logic [VALUE_W-1:0] base_val;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign mod_small = (modulus_r < VALUE_W'(2));

  // Encrypt: take |v - 96| and remember the sign; decrypt uses v as is.
  assign in_below = (mode_r == 1'b0) && (in_value < CHAR_OFFSET);
  always_comb begin
    if (mode_r != 1'b0) begin
      in_diff = in_value;
    end else if (in_below) begin
      in_diff = CHAR_OFFSET - in_value;
    end else begin
      in_diff = in_value - CHAR_OFFSET;
    end
  end

  // A negative difference maps to n - r, unless r is zero.
  assign base_val = (neg_r && (mul_res != '0)) ? modulus_r - mul_res : mul_res;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      modulus_r  <= MODULUS_RST;
      exponent_r <= EXPONENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode_r     <= cfg_data[0];
        CFG_MODULUS:  modulus_r  <= cfg_data;
        CFG_EXPONENT: exponent_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: reduce the base with a multiply by one, then walk the
  // exponent LSB first, one squaring per bit and a multiply for set bits.
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    exp_sh_nxt    = exp_sh_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    mul_start     = 1'b0;
    mul_a         = sq_r;
    mul_b         = sq_r;

    // Drop the held result once the far side takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          neg_nxt = in_below;
          if (mod_small) begin
            // Every residue is zero for a modulus below two.
            acc_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            mul_start = 1'b1;
            mul_a     = in_diff;
            mul_b     = VALUE_W'(1);
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mul_done) begin
          sq_nxt      = base_val;
          acc_nxt     = VALUE_W'(1);
          exp_sh_nxt  = exponent_r;
          bit_cnt_nxt = '0;
          state_nxt   = ST_STEP;
        end
      end
      ST_STEP: begin
        mul_start = 1'b1;
        if (exp_sh_r[0]) begin
          mul_a     = acc_r;
          state_nxt = ST_MACC;
        end else begin
          state_nxt = ST_MSQ;
        end
      end
      ST_MACC: begin
        if (mul_done) begin
          acc_nxt   = mul_res;
          state_nxt = ST_SQS;
        end
      end
      ST_SQS: begin
        mul_start = 1'b1;
        state_nxt = ST_MSQ;
      end
      ST_MSQ: begin
        if (mul_done) begin
          sq_nxt      = mul_res;
          exp_sh_nxt  = {1'b0, exp_sh_r[VALUE_W-1:1]};
          bit_cnt_nxt = bit_cnt_r + 1'b1;
          state_nxt   = (bit_cnt_r == CNT_LAST) ? ST_FIN : ST_STEP;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = {1'b0, acc_r} + (mode_r ? OUT_W'(CHAR_OFFSET) : '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
    end
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    sq_r        <= sq_nxt;
    exp_sh_r    <= exp_sh_nxt;
    out_value_r <= out_value_nxt;
  end

  trcm_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (modulus_r),
    .done    (mul_done),
    .result  (mul_res)
  );

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

### tb/sv/trcm_cipher_checker.sv
// ----------------------------------------------------------------------------
// trcm_cipher_checker: scoreboard for the RSA character exponentiator
// Watches the key register writes and both word channels, computes the
// expected code of every accepted input word and compares it with the
// outgoing words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trcm_cipher_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [trcm_pkg::VALUE_W-1:0]     in_value,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [trcm_pkg::OUT_W-1:0]       out_value,
  input  logic                             cfg_we,
  input  logic [trcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [trcm_pkg::VALUE_W-1:0]     cfg_data,
  output int                               mismatch_total,
  output int                               words_pending
);

  import trcm_pkg::*;

  // Shadow copy of the key registers.
  logic               decrypt_q;
  logic [VALUE_W-1:0] modulus_q;
  logic [VALUE_W-1:0] exponent_q;

  logic [OUT_W-1:0]   expected_codes [$];
  logic [OUT_W-1:0]   code_due;
  int                 errors = 0;

  // Square-and-multiply over all exponent bits, in 64-bit arithmetic.
  function automatic logic [OUT_W-1:0] predict_code(input logic [VALUE_W-1:0] v);
    longint unsigned n;
    longint unsigned base;
    longint unsigned diff;
    longint unsigned acc;
    longint unsigned sq;
    n = modulus_q;
    if (n < 2) begin
      acc = 0;
    end else begin
      if (decrypt_q) begin
        base = v % n;
      end else if (v >= CHAR_OFFSET) begin
        base = (v - CHAR_OFFSET) % n;
      end else begin
        // characters below the offset wrap to a non-negative residue
        diff = (CHAR_OFFSET - v) % n;
        base = (diff == 0) ? 0 : n - diff;
      end
      acc = 1;
      sq  = base;
      for (int b = 0; b < VALUE_W; b++) begin
        if (exponent_q[b]) acc = (acc * sq) % n;
        sq = (sq * sq) % n;
      end
    end
    if (decrypt_q) acc = acc + CHAR_OFFSET;
    return OUT_W'(acc);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      decrypt_q  <= 1'b0;
      modulus_q  <= MODULUS_RST;
      exponent_q <= EXPONENT_RST;
      expected_codes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:     decrypt_q  <= cfg_data[0];
          CFG_MODULUS:  modulus_q  <= cfg_data;
          CFG_EXPONENT: exponent_q <= cfg_data;
          default: ;
        endcase
      end
      // retire the outgoing word before queuing the new one
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          errors++;
          $error("out_value: no word expected, actual %0d", out_value);
        end else begin
          code_due = expected_codes.pop_front();
          if (out_value !== code_due) begin
            errors++;
            $error("out_value: expected %0d, actual %0d", code_due, out_value);
          end
        end
      end
      if (in_valid && !in_stall) expected_codes.push_back(predict_code(in_value));
    end
    mismatch_total <= errors;
    words_pending  <= expected_codes.size();
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the RSA character exponentiator
// Loads a series of keys (mode, modulus, exponent), runs a directed set of
// corner words and then random words per key, with bursty input traffic,
// a patterned output stall and one long output hold-off. The checker
// beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import trcm_pkg::*;

  localparam logic MODE_ENCRYPT  = 1'b0;
  localparam logic MODE_DECRYPT  = 1'b1;
  // Watchdog limit, well above the slowest correct run.
  localparam int   CYCLE_LIMIT   = 4_000_000;
  // Long enough for the block to finish one word, take the next and stall its input.
  localparam int   LONG_HOLD     = 5000;
  // A little over the longest word latency.
  localparam int   DRAIN_CYCLES  = 700;
  localparam int   RANDOM_KEYS   = 10;
  localparam int   WORDS_PER_KEY = 100;
  localparam int   HOLD_KEY      = 3;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [VALUE_W-1:0]   in_value  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     out_value;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MODE;
  logic [VALUE_W-1:0]   cfg_data  = '0;

  int                   mismatch_total;
  int                   words_pending;
  int                   cycle_count = 0;
  int                   burst_left  = 0;
  logic                 long_hold_req = 1'b0;

  // Key currently loaded, used to shape the random words.
  logic                 key_decrypt = MODE_ENCRYPT;
  logic [VALUE_W-1:0]   key_modulus = MODULUS_RST;

  textbook_rsa_char_modexp_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  trcm_cipher_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_total (mismatch_total),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run with errors at the cycle limit, as when the words stop flowing.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // Receiver: switch between stall patterns at random intervals, and
  // once, on request, hold off for a long stretch while words keep coming.
  initial begin
    int  pattern;
    int  left;
    int  held;
    logic hold_done;
    pattern   = 0;
    left      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          pattern = $urandom_range(0, 3);
          left    = $urandom_range(20, 400);
        end
        left--;
        case (pattern)
          0:       out_stall <= 1'b0;                        // free running
          1:       out_stall <= ($urandom_range(0, 1) == 1); // heavy random
          2:       out_stall <= ($urandom_range(0, 7) == 0); // light random
          default: out_stall <= ((left % 5) < 3);            // periodic
        endcase
      end
    end
  end

  // Offer one word and hold it until taken. Bursts of random length are
  // separated by random gaps; a zero gap keeps valid high across bursts.
  task automatic send_word(input logic [VALUE_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid, let every outstanding word drain, then write all three
  // key registers on consecutive cycles.
  task automatic load_key(input logic decrypt, input logic [VALUE_W-1:0] modulus,
                          input logic [VALUE_W-1:0] exponent);
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= VALUE_W'(decrypt);
    @(posedge clk);
    cfg_index <= CFG_MODULUS;
    cfg_data  <= modulus;
    @(posedge clk);
    cfg_index <= CFG_EXPONENT;
    cfg_data  <= exponent;
    @(posedge clk);
    cfg_we      <= 1'b0;
    key_decrypt = decrypt;
    key_modulus = modulus;
  endtask

  // Mostly plausible words for the loaded key: lowercase text, codes 32 to
  // 127 or codes below the offset when encrypting, residues below the modulus
  // when decrypting; the rest is any 16-bit value.
  function automatic logic [VALUE_W-1:0] random_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (key_decrypt) begin
      if (pick < 7 && key_modulus >= 2) return VALUE_W'($urandom_range(0, key_modulus - 1));
      return VALUE_W'($urandom);
    end
    if (pick < 4) return VALUE_W'($urandom_range(97, 122));
    if (pick < 6) return VALUE_W'($urandom_range(32, 127));
    if (pick < 7) return VALUE_W'($urandom_range(0, 95));
    return VALUE_W'($urandom);
  endfunction

  initial begin
    logic               decrypt;
    logic [VALUE_W-1:0] modulus;
    logic [VALUE_W-1:0] exponent;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset key: encrypt, modulus 2, exponent 1.
    send_word(16'd0);
    send_word(16'd65535);
    send_word(16'd97);

    // Small textbook key; offset itself, characters below the offset, top code.
    load_key(MODE_ENCRYPT, 16'd3233, 16'd17);
    send_word(16'd96);
    send_word(16'd97);
    send_word(16'd122);
    send_word(16'd0);
    send_word(16'd95);
    send_word(16'd65535);

    // Zero exponent gives the empty product.
    load_key(MODE_ENCRYPT, 16'd3233, 16'd0);
    send_word(16'd120);

    // Largest modulus and exponent.
    load_key(MODE_ENCRYPT, 16'd65535, 16'd65535);
    send_word(16'd0);
    send_word(16'd65535);
    send_word(16'd21845);

    // Degenerate moduli collapse every residue to zero.
    load_key(MODE_ENCRYPT, 16'd0, 16'd5);
    send_word(16'd100);
    load_key(MODE_ENCRYPT, 16'd1, 16'd7);
    send_word(16'd100);

    // Decrypt with the matching private exponent; include a ciphertext
    // at or above the modulus.
    load_key(MODE_DECRYPT, 16'd3233, 16'd2753);
    send_word(16'd0);
    send_word(16'd3238);
    send_word(16'd65535);
    send_word(16'd855);
    load_key(MODE_DECRYPT, 16'd3233, 16'd0);
    send_word(16'd5);
    load_key(MODE_DECRYPT, 16'd1, 16'd3);
    send_word(16'd300);
    load_key(MODE_DECRYPT, 16'd2, 16'd65535);
    send_word(16'd65535);
    send_word(16'd1);

    // Random keys, each with a run of random words.
    for (int k = 0; k < RANDOM_KEYS; k++) begin
      decrypt = ($urandom_range(0, 1) == 1) ? MODE_DECRYPT : MODE_ENCRYPT;
      case ($urandom_range(0, 9))
        0:       modulus = 16'd2;
        1:       modulus = 16'd65535;
        2:       modulus = VALUE_W'($urandom_range(2, 300));
        3:       modulus = VALUE_W'($urandom_range(2, 255) * $urandom_range(2, 255));
        default: modulus = VALUE_W'($urandom_range(2, 65535));
      endcase
      case ($urandom_range(0, 7))
        0:       exponent = 16'd0;
        1:       exponent = 16'd65535;
        2:       exponent = 16'd1;
        default: exponent = VALUE_W'($urandom);
      endcase
      load_key(decrypt, modulus, exponent);
      // ask the receiver for its long hold-off while this key runs
      if (k == HOLD_KEY) long_hold_req <= 1'b1;
      repeat (WORDS_PER_KEY) send_word(random_word());
    end

    // Drop valid, drain, and give a stray word time to show up.
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && words_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/trcm_pkg.sv
hw/rtl/trcm_modmul.sv
hw/rtl/textbook_rsa_char_modexp_top.sv
tb/sv/trcm_cipher_checker.sv
tb/sv/tb_top.sv
